### rtl/core/crp_pkg.sv
// Shared types and constants for the cell range reference parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package crp_pkg;

    // Payload field widths
    localparam int TEXT_W      = 8;
    localparam int ROW_FIELD_W = 18;
    localparam int COL_FIELD_W = 24;

    // Character codes and radix constants
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam int         COL_RADIX    = 26;

    // Classification of one text byte
    typedef struct packed {
        logic       is_zero;
        logic       is_letter;
        logic       is_digit;
        logic       is_colon;
        logic [4:0] letter_value;   // 1 for A up to 26 for Z
        logic [3:0] digit_value;
    } t_byte_class;

    // Largest bijective base-26 column with n letters (ZZ..Z)
    function automatic longint col_max_value(input int n);
        longint sum;
        longint pw;
        sum = 0;
        pw  = 1;
        for (int k = 0; k < n; k++) begin
            pw  = pw * COL_RADIX;
            sum = sum + pw;
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

### rtl/core/crp_if.sv
// Valid/ready channel interfaces for the cell range reference parser.
// Depends on crp_pkg for the payload widths.
`default_nettype none

interface crp_text_if
    import crp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface crp_range_if
    import crp_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic                          range_valid;
    logic signed [ROW_FIELD_W-1:0] top_row;
    logic        [COL_FIELD_W-1:0] left_column;
    logic signed [ROW_FIELD_W-1:0] bottom_row;
    logic        [COL_FIELD_W-1:0] right_column;

    modport source (output valid, output range_valid, output top_row, output left_column,
                    output bottom_row, output right_column, input ready);
    modport sink   (input valid, input range_valid, input top_row, input left_column,
                    input bottom_row, input right_column, output ready);
endinterface

`default_nettype wire

### rtl/core/crp_decode.sv
// Byte classifier: folds case and splits a text byte into letter, digit, colon, zero.
// Depends on crp_pkg.
`default_nettype none

module crp_decode
    import crp_pkg::*;
(
    input  wire logic [TEXT_W-1:0] i_byte,
    output t_byte_class            o_class
);

    logic [TEXT_W-1:0] w_upper;
    logic [TEXT_W-1:0] w_letter_off;
    logic [TEXT_W-1:0] w_digit_off;

    // Fold lower case onto upper case
    always_comb begin
        if (i_byte >= CHAR_LOWER_A && i_byte <= CHAR_LOWER_Z) begin
            w_upper = i_byte - CASE_OFFSET;
        end else begin
            w_upper = i_byte;
        end
    end

    assign w_letter_off = w_upper - CHAR_UPPER_A + 8'd1;
    assign w_digit_off  = w_upper - CHAR_ZERO;

    // Classify the folded byte
    always_comb begin
        o_class.is_zero      = (i_byte == CHAR_NUL);
        o_class.is_letter    = (w_upper >= CHAR_UPPER_A) && (w_upper <= CHAR_UPPER_Z);
        o_class.is_digit     = (w_upper >= CHAR_ZERO) && (w_upper <= CHAR_NINE);
        o_class.is_colon     = (w_upper == CHAR_COLON);
        o_class.letter_value = w_letter_off[4:0];
        o_class.digit_value  = w_digit_off[3:0];
    end

endmodule

`default_nettype wire

### rtl/core/cell_range_reference_parser_core.sv
// Top level of the cell range reference parser: input register, parse state, result register.
// Depends on crp_pkg, crp_if (crp_text_if, crp_range_if) and crp_decode.
//
//   channel   dir  interface     payload
//   i_text    in   crp_text_if   text_byte[7:0], end_of_text
//   o_range   out  crp_range_if  range_valid, top_row, left_column, bottom_row, right_column
//
// One byte per cycle unless a last byte waits on a stalled result: a request is registered,
// then folded into the parse state in the next cycle; the byte marked end_of_text loads the
// result register, which offers the result on o_range. A stalled result blocks only a
// following last byte, which then holds the input register and so the whole input.
// Reset (i_rst_n low, synchronous) clears the parse state and both valid flags.
// After each result the parse state returns to its reset value for the next text.
`default_nettype none

module cell_range_reference_parser_core
    import crp_pkg::*;
#(
    parameter int MAX_LETTERS = 5,
    parameter int MAX_DIGITS  = 5,
    parameter int MAX_TEXT    = 63
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    crp_text_if.sink    i_text,
    crp_range_if.source o_range
);

    localparam int COL_W = $clog2(col_max_value(MAX_LETTERS) + 1);
    localparam int ROW_W = $clog2(10 ** MAX_DIGITS);
    localparam int LC_W  = $clog2(MAX_LETTERS + 2);
    localparam int DC_W  = $clog2(MAX_DIGITS + 2);
    localparam int POS_W = $clog2(MAX_TEXT + 1);

    // Input register
    logic              r_in_valid;
    logic [TEXT_W-1:0] r_in_byte;
    logic              r_in_last;

    // Parse state
    logic             r_after_colon, n_after_colon;
    logic             r_text_ended,  n_text_ended;
    logic [POS_W-1:0] r_pos,         n_pos;
    logic [LC_W-1:0]  r_lc,          n_lc;
    logic [DC_W-1:0]  r_dc,          n_dc;
    logic [COL_W-1:0] r_col,         n_col;
    logic [ROW_W-1:0] r_row,         n_row;
    logic [ROW_W-1:0] r_saved_row,   n_saved_row;
    logic [COL_W-1:0] r_saved_col,   n_saved_col;
    logic             r_err,         n_err;

    // Result register
    logic                   r_out_valid;
    logic                   r_range_valid;
    logic [ROW_FIELD_W-1:0] r_top_row;
    logic [COL_FIELD_W-1:0] r_left_col;
    logic [ROW_FIELD_W-1:0] r_bottom_row;
    logic [COL_FIELD_W-1:0] r_right_col;

    t_byte_class w_class;
    logic        w_fire;
    logic        w_take;
    logic        w_ok;
    logic [31:0] w_top;
    logic [31:0] w_left;
    logic [31:0] w_bottom;
    logic [31:0] w_right;

    crp_decode u_decode (
        .i_byte  (r_in_byte),
        .o_class (w_class)
    );

    // Advance the registered byte unless it is a last byte facing a full result register that is not taken
    assign w_fire        = r_in_valid && (!r_in_last || !r_out_valid || o_range.ready);
    assign i_text.ready  = !r_in_valid || w_fire;

    // Hold the request in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
        if (i_text.ready && i_text.valid) begin
            r_in_byte <= i_text.text_byte;
            r_in_last <= i_text.end_of_text;
        end
    end

    assign w_take = !r_text_ended && (r_pos < POS_W'(MAX_TEXT));

    // Fold one byte into the parse state
    always_comb begin
        n_after_colon = r_after_colon;
        n_text_ended  = r_text_ended;
        n_pos         = r_pos;
        n_lc          = r_lc;
        n_dc          = r_dc;
        n_col         = r_col;
        n_row         = r_row;
        n_saved_row   = r_saved_row;
        n_saved_col   = r_saved_col;
        n_err         = r_err;
        if (w_take) begin
            if (w_class.is_zero) begin
                n_text_ended = 1'b1;
            end else begin
                n_pos = r_pos + POS_W'(1);
                priority if (w_class.is_letter) begin
                    if (r_lc >= LC_W'(MAX_LETTERS)) begin
                        n_lc  = LC_W'(MAX_LETTERS + 1);
                        n_err = 1'b1;
                    end else begin
                        n_lc  = r_lc + LC_W'(1);
                        n_col = (r_col << 4) + (r_col << 3) + (r_col << 1)
                              + COL_W'(w_class.letter_value);
                    end
                end else if (w_class.is_digit) begin
                    if (r_dc >= DC_W'(MAX_DIGITS)) begin
                        n_dc  = DC_W'(MAX_DIGITS + 1);
                        n_err = 1'b1;
                    end else begin
                        n_dc  = r_dc + DC_W'(1);
                        n_row = (r_row << 3) + (r_row << 1) + ROW_W'(w_class.digit_value);
                    end
                end else if (w_class.is_colon && !r_after_colon) begin
                    if (r_lc == '0 || r_dc == '0) begin
                        n_err = 1'b1;
                    end
                    n_saved_row   = r_row;
                    n_saved_col   = r_col;
                    n_after_colon = 1'b1;
                    n_lc          = '0;
                    n_dc          = '0;
                    n_col         = '0;
                    n_row         = '0;
                end else begin
                    n_err = 1'b1;
                end
            end
        end
    end

    // Judge the range and make both corners zero-based
    assign w_ok = !n_err && n_after_colon && (n_lc != '0) && (n_dc != '0)
               && (n_saved_row <= n_row) && (n_saved_col <= n_col);
    assign w_top    = 32'(n_saved_row) - 32'd1;
    assign w_left   = 32'(n_saved_col) - 32'd1;
    assign w_bottom = 32'(n_row) - 32'd1;
    assign w_right  = 32'(n_col) - 32'd1;

    // Update parse state; drop it back to reset after a last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in_last)) begin
            r_after_colon <= 1'b0;
            r_text_ended  <= 1'b0;
            r_pos         <= '0;
            r_lc          <= '0;
            r_dc          <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_saved_row   <= '0;
            r_saved_col   <= '0;
            r_err         <= 1'b0;
        end else if (w_fire) begin
            r_after_colon <= n_after_colon;
            r_text_ended  <= n_text_ended;
            r_pos         <= n_pos;
            r_lc          <= n_lc;
            r_dc          <= n_dc;
            r_col         <= n_col;
            r_row         <= n_row;
            r_saved_row   <= n_saved_row;
            r_saved_col   <= n_saved_col;
            r_err         <= n_err;
        end
    end

    // Load the result register on a last byte, release it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_range.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && r_in_last) begin
            r_range_valid <= w_ok;
            r_top_row     <= w_ok ? w_top[ROW_FIELD_W-1:0]    : '0;
            r_left_col    <= w_ok ? w_left[COL_FIELD_W-1:0]   : '0;
            r_bottom_row  <= w_ok ? w_bottom[ROW_FIELD_W-1:0] : '0;
            r_right_col   <= w_ok ? w_right[COL_FIELD_W-1:0]  : '0;
        end
    end

    assign o_range.valid        = r_out_valid;
    assign o_range.range_valid  = r_range_valid;
    assign o_range.top_row      = $signed(r_top_row);
    assign o_range.left_column  = r_left_col;
    assign o_range.bottom_row   = $signed(r_bottom_row);
    assign o_range.right_column = r_right_col;

endmodule

`default_nettype wire

### tb/cell_range_reference_parser_core_tb.sv
// Self-checking testbench for cell_range_reference_parser_core: streams range texts
// through the text channel and checks each decoded range against a local parse model.
// Depends on crp_pkg and the crp_text_if / crp_range_if interfaces.
`default_nettype none

module cell_range_reference_parser_core_tb;
    import crp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LETTERS  = 5;
    localparam int MAX_DIGITS   = 5;
    localparam int MAX_TEXT     = 63;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_BYTES = 1560;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic                   range_valid;
        logic [ROW_FIELD_W-1:0] top_row;
        logic [COL_FIELD_W-1:0] left_column;
        logic [ROW_FIELD_W-1:0] bottom_row;
        logic [COL_FIELD_W-1:0] right_column;
    } t_range_result;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_PERIODIC
    } t_ready_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crp_text_if  text_ch ();
    crp_range_if range_ch ();

    cell_range_reference_parser_core #(
        .MAX_LETTERS(MAX_LETTERS),
        .MAX_DIGITS (MAX_DIGITS),
        .MAX_TEXT   (MAX_TEXT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_text (text_ch),
        .o_range(range_ch)
    );

    // Free-running clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int cycle_count = 0;
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Parse model state
    logic        in_second_cell;
    logic        text_stopped;
    int unsigned bytes_counted;
    int unsigned letters_seen;
    int unsigned digits_seen;
    int unsigned col_sum;
    int unsigned row_sum;
    int unsigned first_row_raw;
    int unsigned first_col_raw;
    logic        text_bad;

    t_range_result range_expected[$];
    logic [7:0]    text_buf[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int valid_ranges   = 0;
    int bad_ranges     = 0;
    int texts_sent     = 0;
    int bytes_sent     = 0;
    int burst_left     = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d (cycle %0d): %s", results_seen, cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic void clear_parse_state();
        in_second_cell = 1'b0;
        text_stopped   = 1'b0;
        bytes_counted  = 0;
        letters_seen   = 0;
        digits_seen    = 0;
        col_sum        = 0;
        row_sum        = 0;
        first_row_raw  = 0;
        first_col_raw  = 0;
        text_bad       = 1'b0;
    endfunction

    // Fold one accepted byte into the parse model; queue the range on the last byte
    task automatic track_byte(input logic [7:0] ch_in, input logic last);
        logic [7:0]    ch;
        logic          ok;
        t_range_result want;
        ch = ch_in;
        if (!text_stopped && bytes_counted < MAX_TEXT) begin
            if (ch == CHAR_NUL) begin
                text_stopped = 1'b1;
            end else begin
                bytes_counted++;
                if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ch = ch - CASE_OFFSET;
                if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
                    if (letters_seen >= MAX_LETTERS) begin
                        letters_seen = MAX_LETTERS + 1;
                        text_bad     = 1'b1;
                    end else begin
                        letters_seen++;
                        col_sum = col_sum * COL_RADIX + (ch - CHAR_UPPER_A + 1);
                    end
                end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                    if (digits_seen >= MAX_DIGITS) begin
                        digits_seen = MAX_DIGITS + 1;
                        text_bad    = 1'b1;
                    end else begin
                        digits_seen++;
                        row_sum = row_sum * 10 + (ch - CHAR_ZERO);
                    end
                end else if (ch == CHAR_COLON && !in_second_cell) begin
                    if (letters_seen == 0 || digits_seen == 0) text_bad = 1'b1;
                    first_row_raw  = row_sum;
                    first_col_raw  = col_sum;
                    in_second_cell = 1'b1;
                    letters_seen   = 0;
                    digits_seen    = 0;
                    col_sum        = 0;
                    row_sum        = 0;
                end else begin
                    text_bad = 1'b1;
                end
            end
        end
        if (last) begin
            ok = !text_bad && in_second_cell && letters_seen > 0 && digits_seen > 0 &&
                 first_row_raw <= row_sum && first_col_raw <= col_sum;
            want = '0;
            want.range_valid = ok;
            if (ok) begin
                want.top_row      = ROW_FIELD_W'(first_row_raw - 1);
                want.left_column  = COL_FIELD_W'(first_col_raw - 1);
                want.bottom_row   = ROW_FIELD_W'(row_sum - 1);
                want.right_column = COL_FIELD_W'(col_sum - 1);
                valid_ranges++;
            end else begin
                bad_ranges++;
            end
            range_expected.push_back(want);
            clear_parse_state();
        end
    endtask

    // Send one request; hold valid across bursts, drop it only in a gap
    task automatic send_byte(input logic [7:0] ch, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= ch;
        text_ch.end_of_text <= last;
        do @(posedge i_clk); while (!text_ch.ready);
        burst_left--;
        bytes_sent++;
        track_byte(ch, last);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
        texts_sent++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // Append one cell; letters lead unless mixed, where they interleave with digits
    task automatic push_cell(input int letters, input int digits, input bit mixed);
        int         li;
        int         di;
        logic [7:0] ch;
        li = 0;
        di = 0;
        while (li < letters || di < digits) begin
            if (di >= digits || (li < letters && (!mixed || $urandom_range(0, 1) == 1))) begin
                ch = CHAR_UPPER_A + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 3) == 0) ch = ch + CASE_OFFSET;
                li++;
            end else begin
                ch = CHAR_ZERO + 8'($urandom_range(0, 9));
                di++;
            end
            text_buf.push_back(ch);
        end
    endtask

    // Two in-limit cells; the second is never shorter, so order holds often
    task automatic push_pair(input bit mixed);
        int nl;
        int nd;
        nl = $urandom_range(1, MAX_LETTERS);
        nd = $urandom_range(1, MAX_DIGITS);
        push_cell(nl, nd, mixed);
        text_buf.push_back(CHAR_COLON);
        push_cell($urandom_range(nl, MAX_LETTERS), $urandom_range(nd, MAX_DIGITS), mixed);
    endtask

    task automatic test_well_formed_ranges();
        string texts [7];
        texts = '{"A1:A1", "AC23:BDF424", "a1:zz99", "ZZZZZ99999:ZZZZZ99999",
                  "A0:B0", "1a2:B3c4", "Az1:aZ1"};
        foreach (texts[i]) begin
            push_str(texts[i]);
            send_text();
        end
    endtask

    task automatic test_malformed_ranges();
        string      texts [8];
        logic [7:0] stray [6];
        texts = '{"B1:A1", "A2:A1", "A1B2", ":A1", "A1:B", "A1:B2:C3",
                  "AAAAAA1:B2", "A123456:B2"};
        stray = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'hFF};
        foreach (texts[i]) begin
            push_str(texts[i]);
            send_text();
        end
        // Characters just outside the letter and digit ranges, and 8'hFF
        foreach (stray[i]) begin
            push_str("A1:B2");
            text_buf.push_back(stray[i]);
            send_text();
        end
    endtask

    task automatic test_text_termination();
        // Zero byte ends the text; junk after it is ignored
        push_str("A1:B2");
        text_buf.push_back(CHAR_NUL);
        push_str("::x");
        send_text();
        // Lone zero byte as the whole text
        text_buf.push_back(CHAR_NUL);
        send_text();
        // Text past the counted length
        push_str("A1:B");
        repeat (70) text_buf.push_back(CHAR_ZERO + 8'd2);
        send_text();
    endtask

    task automatic test_random_ranges();
        int pick;
        int pos;
        int stop_at;
        bit mixed;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            pick  = $urandom_range(0, 99);
            mixed = ($urandom_range(0, 4) == 0);
            if (pick < 65) begin
                push_pair(mixed);
            end else if (pick < 73) begin
                // Corrupt one byte of a good range
                push_pair(mixed);
                pos = $urandom_range(0, text_buf.size() - 1);
                text_buf[pos] = 8'($urandom_range(0, 255));
            end else if (pick < 79) begin
                push_pair(mixed);
                text_buf.push_back(CHAR_NUL);
                repeat ($urandom_range(0, 5)) text_buf.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 84) begin
                // Cells that may run past the letter or digit limit
                push_cell($urandom_range(1, MAX_LETTERS + 2), $urandom_range(1, MAX_DIGITS + 2),
                          mixed);
                text_buf.push_back(CHAR_COLON);
                push_cell($urandom_range(1, MAX_LETTERS + 2), $urandom_range(1, MAX_DIGITS + 2),
                          mixed);
            end else if (pick < 88) begin
                // Missing colon, missing first cell, or a cell without letters or digits
                case ($urandom_range(0, 2))
                    0: push_cell($urandom_range(1, MAX_LETTERS), $urandom_range(1, MAX_DIGITS),
                                 mixed);
                    1: begin
                        text_buf.push_back(CHAR_COLON);
                        push_cell($urandom_range(1, MAX_LETTERS), $urandom_range(1, MAX_DIGITS),
                                  mixed);
                    end
                    default: begin
                        push_cell($urandom_range(1, MAX_LETTERS), $urandom_range(1, MAX_DIGITS),
                                  mixed);
                        text_buf.push_back(CHAR_COLON);
                        if ($urandom_range(0, 1) == 0) push_cell(0, $urandom_range(1, MAX_DIGITS), 0);
                        else push_cell($urandom_range(1, MAX_LETTERS), 0, 0);
                    end
                endcase
            end else if (pick < 92) begin
                repeat ($urandom_range(60, 80)) begin
                    if ($urandom_range(0, 1) == 0)
                        text_buf.push_back(CHAR_UPPER_A + 8'($urandom_range(0, 25)));
                    else
                        text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                // Second colon opens a third cell
                push_pair(mixed);
                text_buf.push_back(CHAR_COLON);
                push_cell($urandom_range(1, 3), $urandom_range(1, 3), mixed);
            end
            send_text();
        end
    endtask

    // Check each accepted range and drive ready on a mode that changes over time
    initial begin : range_monitor
        t_range_result want;
        t_ready_mode   mode;
        int            mode_left;
        range_ch.ready <= 1'b0;
        mode      = READY_ALWAYS;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && range_ch.valid && range_ch.ready) begin
                results_seen++;
                if (range_expected.size() == 0) begin
                    report_mismatch("range result with no text pending");
                end else begin
                    want = range_expected.pop_front();
                    if (range_ch.range_valid !== want.range_valid)
                        report_mismatch($sformatf("range_valid got %0b want %0b",
                                                  range_ch.range_valid, want.range_valid));
                    if (range_ch.top_row !== want.top_row)
                        report_mismatch($sformatf("top_row got %0d want %0d",
                                                  $signed(range_ch.top_row), $signed(want.top_row)));
                    if (range_ch.left_column !== want.left_column)
                        report_mismatch($sformatf("left_column got %0d want %0d",
                                                  range_ch.left_column, want.left_column));
                    if (range_ch.bottom_row !== want.bottom_row)
                        report_mismatch($sformatf("bottom_row got %0d want %0d",
                                                  $signed(range_ch.bottom_row),
                                                  $signed(want.bottom_row)));
                    if (range_ch.right_column !== want.right_column)
                        report_mismatch($sformatf("right_column got %0d want %0d",
                                                  range_ch.right_column, want.right_column));
                end
            end
            if (mode_left == 0) begin
                mode      = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                READY_ALWAYS:   range_ch.ready <= 1'b1;
                READY_RANDOM:   range_ch.ready <= ($urandom_range(0, 1) == 1);
                READY_SPARSE:   range_ch.ready <= ($urandom_range(0, 7) == 0);
                READY_PERIODIC: range_ch.ready <= ((cycle_count % 8) < 3);
                default:        range_ch.ready <= 1'b1;
            endcase
        end
    end

    // Stop a hung run
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d ranges pending", cycle_count,
                 range_expected.size());
        $display("cell_range_reference_parser_core regression: fail");
        $finish;
    end

    initial begin : main_sequence
        i_rst_n             <= 1'b0;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= '0;
        text_ch.end_of_text <= 1'b0;
        clear_parse_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_well_formed_ranges();
        test_malformed_ranges();
        test_text_termination();
        test_random_ranges();
        text_ch.valid <= 1'b0;

        // Drain outstanding ranges, then let the pipeline settle
        while (range_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d range texts in %0d bytes over %0d cycles", texts_sent, bytes_sent,
                 cycle_count);
        $display("predicted %0d valid and %0d rejected ranges, %0d mismatches", valid_ranges,
                 bad_ranges, mismatch_count);
        if (mismatch_count == 0) begin
            $display("cell_range_reference_parser_core regression: pass");
        end else begin
            $display("cell_range_reference_parser_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
